FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: implication");

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/k3m_pkg.sv
package k3m_pkg;

   // Image geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W      = 9;
   localparam int COUNT_W    = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;

   // Response kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // Per-pixel sequencing: nine neighborhood reads, a wait for the last read data, then the decide step
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST_RD = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DECIDE  = 4'd10;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_RUN  = 2'd2
   } state_type;

   typedef enum logic [2:0] {
      PH_MARK  = 3'd0,
      PH_P1    = 3'd1,
      PH_P2    = 3'd2,
      PH_P3    = 3'd3,
      PH_P4    = 3'd4,
      PH_P5    = 3'd5,
      PH_FINAL = 3'd6
   } phase_type;

   typedef logic [15:0] tab_type [16];

   localparam tab_type TAB_P0 = '{
      16'h130B, 16'h008B, 16'h0000, 16'h808B, 16'h0000, 16'h0000, 16'h8000, 16'h808B,
      16'h5101, 16'h0001, 16'h0000, 16'h0001, 16'hD101, 16'h0001, 16'hD101, 16'hD1DE};
   localparam tab_type TAB_P1 = '{
      16'h0102, 16'h0008, 16'h0000, 16'h0080, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
      16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h0000};
   localparam tab_type TAB_P2 = '{
      16'h0103, 16'h000A, 16'h0000, 16'h0088, 16'h0000, 16'h0000, 16'h0000, 16'h8080,
      16'h1100, 16'h0000, 16'h0000, 16'h0000, 16'h5000, 16'h0000, 16'hC000, 16'h8000};
   localparam tab_type TAB_P3 = '{
      16'h0103, 16'h000B, 16'h0000, 16'h008A, 16'h0000, 16'h0000, 16'h0000, 16'h8088,
      16'h1101, 16'h0000, 16'h0000, 16'h0000, 16'h5100, 16'h0000, 16'hD000, 16'hC080};
   localparam tab_type TAB_P4 = '{
      16'h0103, 16'h000B, 16'h0000, 16'h008B, 16'h0000, 16'h0000, 16'h0000, 16'h808A,
      16'h1101, 16'h0001, 16'h0000, 16'h0000, 16'h5101, 16'h0000, 16'hD100, 16'hD0C8};
   localparam tab_type TAB_P5 = '{
      16'h0103, 16'h000B, 16'h0000, 16'h008B, 16'h0000, 16'h0000, 16'h0000, 16'h808A,
      16'h1101, 16'h0001, 16'h0000, 16'h0001, 16'h5101, 16'h0000, 16'hD101, 16'hD0DA};

   // Table lookup: bit (15 - code%16) of entry code/16
   function automatic logic tab_hit(input tab_type tab, input logic [7:0] code);
      logic [15:0] entry;
      entry = tab[code[7:4]];
      return entry[~code[3:0]];
   endfunction

   // Deletion table of the current phase; mark and final sweeps use P0
   function automatic logic phase_hit(input phase_type ph, input logic [7:0] code);
      logic hit;
      case (ph)
         PH_P1:   hit = tab_hit(TAB_P1, code);
         PH_P2:   hit = tab_hit(TAB_P2, code);
         PH_P3:   hit = tab_hit(TAB_P3, code);
         PH_P4:   hit = tab_hit(TAB_P4, code);
         PH_P5:   hit = tab_hit(TAB_P5, code);
         default: hit = tab_hit(TAB_P0, code);
      endcase
      return hit;
   endfunction

endpackage

FILE: hdl/k3m_binary_thinning.sv
// K3M binary thinning engine. The image (up to 256 x 256 one-bit pixels, row-major) lives in a
// single-port-read memory; a second memory holds the border marks. A pixel write gives no
// response; a pixel read answers through the registered memory read port and then the response
// register. A run transaction thins the image in place and answers with the number of passes.
// Every pixel visit makes nine reads of the 3x3 neighborhood through the one image read port,
// waits for the last read data to land, then decides and writes back. Each pass sweeps the image
// six times (marking, then phases 1 to 5) and one final sweep follows. No request is taken while
// a run or a pixel read is busy or while a response waits to be taken.
module k3m_binary_thinning (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [7:0]                   req_col,
   input  logic [7:0]                   req_row,
   input  logic                         req_foreground,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_answer_kind,
   output logic                         rsp_pixel_value,
   output logic [16:0]                  rsp_pass_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [8:0]                   csr_data
);

   k3m_pkg::state_type state_ff, state_in;
   k3m_pkg::phase_type phase_ff, phase_in;
   logic [k3m_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [k3m_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [k3m_pkg::COL_W-1:0]   col_ff, col_in;
   logic                        changed_ff, changed_in;
   logic [k3m_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        center_ff, center_in;
   logic                        mark_ff, mark_in;
   logic [7:0]                  code_ff, code_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        rd_inb_ff, rd_inb_in;
   logic [k3m_pkg::STEP_W-1:0]  rd_pos_ff, rd_pos_in;
   logic                        inside_ff, inside_in;
   logic [k3m_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_kind_ff, rsp_kind_in;
   logic                        rsp_pixel_ff, rsp_pixel_in;
   logic [k3m_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        req_take, rsp_take;
   logic [k3m_pkg::DIM_W-1:0]   w_use, h_use;
   logic                        req_inside;
   logic                        nb_up, nb_dn, nb_lf, nb_rt, nb_inb;
   logic [k3m_pkg::ROW_W-1:0]   nb_row;
   logic [k3m_pkg::COL_W-1:0]   nb_col;
   logic                        img_wr_en, img_wr_data, img_rd_en, img_rd_data;
   logic [k3m_pkg::ADDR_W-1:0]  img_wr_addr, img_rd_addr;
   logic                        mrk_wr_en, mrk_wr_data, mrk_rd_en, mrk_rd_data;
   logic                        decide, last_col, last_row, del_px, new_pass;
   logic [2:0]                  code_idx;
   logic [k3m_pkg::STEP_W-1:0]  pos_dec;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != k3m_pkg::ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;

   // Dimensions in use: zero reads as one, oversize clamps to the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_use = k3m_pkg::DIM_W'(1);
      end else if (width_ff > k3m_pkg::DIM_W'(k3m_pkg::MAX_WIDTH)) begin
         w_use = k3m_pkg::DIM_W'(k3m_pkg::MAX_WIDTH);
      end else begin
         w_use = width_ff;
      end
      if (height_ff == '0) begin
         h_use = k3m_pkg::DIM_W'(1);
      end else if (height_ff > k3m_pkg::DIM_W'(k3m_pkg::MAX_HEIGHT)) begin
         h_use = k3m_pkg::DIM_W'(k3m_pkg::MAX_HEIGHT);
      end else begin
         h_use = height_ff;
      end
   end

   assign req_inside = ({1'b0, req_col} < w_use) && ({1'b0, req_row} < h_use);

   // Neighbor offset for the current read step: center, then N clockwise to NW
   always_comb begin
      nb_up = 1'b0;
      nb_dn = 1'b0;
      nb_lf = 1'b0;
      nb_rt = 1'b0;
      case (step_ff)
         4'd1: begin nb_up = 1'b1; end
         4'd2: begin nb_up = 1'b1; nb_rt = 1'b1; end
         4'd3: begin nb_rt = 1'b1; end
         4'd4: begin nb_dn = 1'b1; nb_rt = 1'b1; end
         4'd5: begin nb_dn = 1'b1; end
         4'd6: begin nb_dn = 1'b1; nb_lf = 1'b1; end
         4'd7: begin nb_lf = 1'b1; end
         4'd8: begin nb_up = 1'b1; nb_lf = 1'b1; end
         default: begin end
      endcase
   end

   // Outside neighbors read as background
   assign nb_inb = !(nb_up && row_ff == '0) &&
                   !(nb_dn && ({1'b0, row_ff} + k3m_pkg::DIM_W'(1)) >= h_use) &&
                   !(nb_lf && col_ff == '0) &&
                   !(nb_rt && ({1'b0, col_ff} + k3m_pkg::DIM_W'(1)) >= w_use);
   assign nb_row = row_ff - k3m_pkg::ROW_W'(nb_up) + k3m_pkg::ROW_W'(nb_dn);
   assign nb_col = col_ff - k3m_pkg::COL_W'(nb_lf) + k3m_pkg::COL_W'(nb_rt);

   // Decide cycle terms
   assign decide   = (state_ff == k3m_pkg::ST_RUN) && (step_ff == k3m_pkg::STEP_DECIDE);
   assign last_col = ({1'b0, col_ff} + k3m_pkg::DIM_W'(1)) == w_use;
   assign last_row = ({1'b0, row_ff} + k3m_pkg::DIM_W'(1)) == h_use;
   assign del_px   = center_ff && k3m_pkg::phase_hit(phase_ff, code_ff) &&
                     ((phase_ff == k3m_pkg::PH_FINAL) ||
                      ((phase_ff != k3m_pkg::PH_MARK) && mark_ff));
   assign new_pass = (phase_ff == k3m_pkg::PH_P5) && (changed_ff || del_px);
   assign pos_dec  = rd_pos_ff - k3m_pkg::STEP_W'(1);
   assign code_idx = pos_dec[2:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         k3m_pkg::ST_IDLE: begin
            if (req_take && req_operation == k3m_pkg::OP_READ) begin
               state_in = k3m_pkg::ST_READ;
            end else if (req_take && req_operation == k3m_pkg::OP_RUN) begin
               state_in = k3m_pkg::ST_RUN;
            end
         end
         k3m_pkg::ST_READ: begin
            state_in = k3m_pkg::ST_IDLE;
         end
         k3m_pkg::ST_RUN: begin
            if (decide && last_col && last_row && phase_ff == k3m_pkg::PH_FINAL) begin
               state_in = k3m_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = k3m_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      changed_in   = changed_ff;
      count_in     = count_ff;
      center_in    = center_ff;
      mark_in      = mark_ff;
      code_in      = code_ff;
      rd_pend_in   = 1'b0;
      rd_inb_in    = rd_inb_ff;
      rd_pos_in    = rd_pos_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_count_in = rsp_count_ff;
      img_wr_en    = 1'b0;
      img_wr_addr  = {row_ff, col_ff};
      img_wr_data  = 1'b0;
      img_rd_en    = 1'b0;
      img_rd_addr  = {nb_row, nb_col};
      mrk_wr_en    = 1'b0;
      mrk_wr_data  = 1'b0;
      mrk_rd_en    = 1'b0;

      // Capture neighborhood read data in the cycle after issue
      if (rd_pend_ff) begin
         if (rd_pos_ff == '0) begin
            center_in = img_rd_data && rd_inb_ff;
            mark_in   = mrk_rd_data;
         end else begin
            code_in[code_idx] = img_rd_data && rd_inb_ff;
         end
      end

      case (state_ff)
         k3m_pkg::ST_IDLE: begin
            img_rd_addr = {req_row, req_col};
            img_wr_addr = {req_row, req_col};
            img_wr_data = req_foreground;
            inside_in   = req_inside;
            if (req_take && req_operation == k3m_pkg::OP_WRITE) begin
               img_wr_en = req_inside;
            end
            if (req_take && req_operation == k3m_pkg::OP_READ) begin
               img_rd_en = 1'b1;
            end
            if (req_take && req_operation == k3m_pkg::OP_RUN) begin
               phase_in   = k3m_pkg::PH_MARK;
               step_in    = '0;
               row_in     = '0;
               col_in     = '0;
               changed_in = 1'b0;
               count_in   = k3m_pkg::COUNT_W'(1);
            end
         end
         k3m_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = k3m_pkg::KIND_PIXEL;
            rsp_pixel_in = img_rd_data && inside_ff;
            rsp_count_in = '0;
         end
         k3m_pkg::ST_RUN: begin
            if (step_ff <= k3m_pkg::STEP_LAST_RD) begin
               img_rd_en  = 1'b1;
               mrk_rd_en  = (step_ff == '0);
               rd_pend_in = 1'b1;
               rd_inb_in  = nb_inb;
               rd_pos_in  = step_ff;
            end
            if (decide) begin
               step_in = '0;
               // Marking sweep records border pixels; other sweeps delete in place
               if (phase_ff == k3m_pkg::PH_MARK) begin
                  mrk_wr_en   = 1'b1;
                  mrk_wr_data = center_ff && k3m_pkg::tab_hit(k3m_pkg::TAB_P0, code_ff);
               end else begin
                  img_wr_en = del_px;
                  if (phase_ff != k3m_pkg::PH_FINAL && del_px) begin
                     changed_in = 1'b1;
                  end
               end
               // Raster advance and sweep sequencing
               if (last_col) begin
                  col_in = '0;
                  row_in = last_row ? '0 : row_ff + k3m_pkg::ROW_W'(1);
               end else begin
                  col_in = col_ff + k3m_pkg::COL_W'(1);
               end
               if (last_col && last_row) begin
                  case (phase_ff)
                     k3m_pkg::PH_MARK: phase_in = k3m_pkg::PH_P1;
                     k3m_pkg::PH_P1:   phase_in = k3m_pkg::PH_P2;
                     k3m_pkg::PH_P2:   phase_in = k3m_pkg::PH_P3;
                     k3m_pkg::PH_P3:   phase_in = k3m_pkg::PH_P4;
                     k3m_pkg::PH_P4:   phase_in = k3m_pkg::PH_P5;
                     k3m_pkg::PH_P5: begin
                        if (new_pass) begin
                           phase_in   = k3m_pkg::PH_MARK;
                           changed_in = 1'b0;
                           if (count_ff != k3m_pkg::COUNT_MAX) begin
                              count_in = count_ff + k3m_pkg::COUNT_W'(1);
                           end
                        end else begin
                           phase_in = k3m_pkg::PH_FINAL;
                        end
                     end
                     default: begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = k3m_pkg::KIND_DONE;
                        rsp_pixel_in = 1'b0;
                        rsp_count_in = count_ff;
                     end
                  endcase
               end
            end else begin
               step_in = step_ff + k3m_pkg::STEP_W'(1);
            end
         end
         default: begin end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= k3m_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         width_ff     <= k3m_pkg::DIM_W'(k3m_pkg::MAX_WIDTH);
         height_ff    <= k3m_pkg::DIM_W'(k3m_pkg::MAX_HEIGHT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         if (csr_valid && csr_ready && csr_index == k3m_pkg::CSR_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_valid && csr_ready && csr_index == k3m_pkg::CSR_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      step_ff      <= step_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      changed_ff   <= changed_in;
      center_ff    <= center_in;
      mark_ff      <= mark_in;
      code_ff      <= code_in;
      rd_inb_ff    <= rd_inb_in;
      rd_pos_ff    <= rd_pos_in;
      inside_ff    <= inside_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Image store
   k3m_ram #(
      .WIDTH(1),
      .DEPTH(k3m_pkg::PIXELS)
   ) u_image (
      .clock  (clock),
      .wr_en  (img_wr_en),
      .wr_addr(img_wr_addr),
      .wr_data(img_wr_data),
      .rd_en  (img_rd_en),
      .rd_addr(img_rd_addr),
      .rd_data(img_rd_data)
   );

   // Border marks, rewritten for every pixel in use by each marking sweep
   k3m_ram #(
      .WIDTH(1),
      .DEPTH(k3m_pkg::PIXELS)
   ) u_marks (
      .clock  (clock),
      .wr_en  (mrk_wr_en),
      .wr_addr({row_ff, col_ff}),
      .wr_data(mrk_wr_data),
      .rd_en  (mrk_rd_en),
      .rd_addr({row_ff, col_ff}),
      .rd_data(mrk_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_answer_kind = rsp_kind_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_pass_count  = rsp_count_ff;

endmodule

FILE: hdl/k3m_ram.sv
module k3m_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/k3m_checker.sv
`include "assert_macros.svh"

module k3m_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_answer_kind,
   input logic        rsp_pixel_value,
   input logic [16:0] rsp_pass_count
);

   // A stalled request stays offered
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid)

   // A pending response holds until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // No new transaction while a response is waiting
   `ASSERT_IMPLY(a_no_take_pending, clock, reset, rsp_valid, req_stall)

   // A pixel read answer carries no pass count
   `ASSERT_IMPLY(a_read_fields, clock, reset, rsp_valid && !rsp_answer_kind, rsp_pass_count == '0)

   // A finished run counts at least one pass and reports no pixel
   `ASSERT_IMPLY(a_run_fields, clock, reset, rsp_valid && rsp_answer_kind, !rsp_pixel_value && rsp_pass_count != '0)

endmodule

bind k3m_binary_thinning k3m_checker u_k3m_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_answer_kind(rsp_answer_kind),
   .rsp_pixel_value(rsp_pixel_value),
   .rsp_pass_count (rsp_pass_count)
);
